### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/btrm_pkg.sv
// Shared constants and types of the transfer rate meter.
package btrm_pkg;

  localparam int BUCKETS_DEF = 32;

  localparam int TIME_W  = 32;
  localparam int BYTES_W = 32;
  localparam int RATE_W  = 32;
  localparam int IV_W    = 12;
  localparam int SUM_W   = 64;
  localparam int DEN_W   = 44;
  localparam int DIV_W   = 64;
  localparam int CNT_W   = 6;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 1'b0;

  localparam logic [IV_W-1:0]   IV_MIN   = 12'd2;
  localparam logic [IV_W-1:0]   IV_RST   = 12'd2;
  localparam logic [RATE_W-1:0] RATE_SAT = 32'hFFFF_FFFF;
  localparam logic [TIME_W-1:0] TICK_MAX = 32'hFFFF_FFFF;

  localparam logic [CNT_W-1:0] ITER_NARROW = 6'd31;
  localparam logic [CNT_W-1:0] ITER_WIDE   = 6'd63;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

endpackage

### hw/rtl/btrm_div.sv
// Shared restoring divider, one quotient bit per cycle.
module btrm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  btrm_pkg::div_req_t           req,
  input  logic [btrm_pkg::DIV_W-1:0]   dividend,
  input  logic [btrm_pkg::DEN_W-1:0]   divisor,
  output logic                         done,
  output logic [btrm_pkg::DIV_W-1:0]   quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [btrm_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [btrm_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic [btrm_pkg::DIV_W-1:0]    dvd_r, dvd_nxt;
  logic [btrm_pkg::DEN_W-1:0]    dvs_r, dvs_nxt;
  logic [btrm_pkg::DEN_W:0]      rem_sh;
  logic [btrm_pkg::DEN_W:0]      rem_sub;
  logic                          ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[btrm_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.wide ? btrm_pkg::ITER_WIDE : btrm_pkg::ITER_NARROW;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[btrm_pkg::DEN_W-1:0] : rem_sh[btrm_pkg::DEN_W-1:0];
      dvd_nxt = {dvd_r[btrm_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - btrm_pkg::CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

### hw/rtl/bucketed_transfer_rate_meter_unit.sv
// Top level of the bucketed transfer rate meter.
// Each transfer divides its time by the interval to get a tick; one with a nonzero byte
// count adds it to the bucket of that tick (taking over the bucket at the ring pointer when
// no bucket holds it). Then it sums the buckets within BUCKETS ticks and divides by the
// elapsed seconds. One item at a time; a query-only transfer skips the search and update.
// The work is done by one shared divider that makes one quotient bit a cycle (32 bits for
// the tick, 64 for the rate) and by the bucket memory, read one entry a cycle in the search
// and summing passes. A finished rate waits in the output register while the next transfer
// is taken.
module bucketed_transfer_rate_meter_unit #(
  parameter int BUCKETS = btrm_pkg::BUCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [btrm_pkg::TIME_W-1:0]    in_current_time,
  input  logic [btrm_pkg::BYTES_W-1:0]   in_byte_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [btrm_pkg::RATE_W-1:0]    out_rate,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btrm_pkg::ADDR_W-1:0]    paddr,
  input  logic [btrm_pkg::DATA_W-1:0]    pwdata,
  output logic [btrm_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int AW = $clog2(BUCKETS);
  localparam int CW = $clog2(BUCKETS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TICK = 3'd1;
  localparam logic [2:0] ST_SRCH = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_QUOT = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]                      state_r, state_nxt;
  logic [btrm_pkg::IV_W-1:0]       iv_r;
  logic [btrm_pkg::IV_W-1:0]       iv_eff;
  logic [btrm_pkg::BYTES_W-1:0]    byte_r, byte_nxt;
  logic [btrm_pkg::TIME_W-1:0]     tick_r, tick_nxt;
  logic [btrm_pkg::TIME_W-1:0]     bnd_r, bnd_nxt;
  logic                            all_r, all_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic                            pend_r, pend_nxt;
  logic [AW-1:0]                   pidx_r, pidx_nxt;
  logic                            found_r, found_nxt;
  logic [AW-1:0]                   slot_r, slot_nxt;
  logic [btrm_pkg::SUM_W-1:0]      old_r, old_nxt;
  logic [AW-1:0]                   ring_r, ring_nxt;
  logic [btrm_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [btrm_pkg::TIME_W-1:0]     start_r, start_nxt;
  logic [btrm_pkg::RATE_W-1:0]     res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [btrm_pkg::RATE_W-1:0]     out_rate_r, out_rate_nxt;
  logic [BUCKETS-1:0]              vld_r, vld_nxt;

  logic [btrm_pkg::TIME_W-1:0]     tick_mem [BUCKETS];
  logic [btrm_pkg::SUM_W-1:0]      bytes_mem [BUCKETS];
  logic [btrm_pkg::TIME_W-1:0]     rd_tick_r;
  logic [btrm_pkg::SUM_W-1:0]      rd_bytes_r;
  logic                            rd_vld_r;
  logic [btrm_pkg::TIME_W-1:0]     rd_tick;
  logic [btrm_pkg::SUM_W-1:0]      rd_bytes;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [btrm_pkg::SUM_W-1:0]      wr_bytes;

  btrm_pkg::div_req_t              div_req;
  logic [btrm_pkg::DIV_W-1:0]      div_dividend;
  logic [btrm_pkg::DEN_W-1:0]      div_divisor;
  logic                            div_done;
  logic [btrm_pkg::DIV_W-1:0]      div_quot;

  logic                            cfg_wr;
  logic                            in_acc;
  logic                            in_win;
  logic [btrm_pkg::TIME_W-1:0]     elapsed;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[btrm_pkg::ADDR_W-1:2] == btrm_pkg::REG_INTERVAL);
  assign prdata = (paddr[btrm_pkg::ADDR_W-1:2] == btrm_pkg::REG_INTERVAL) ?
                  {{(btrm_pkg::DATA_W - btrm_pkg::IV_W){1'b0}}, iv_r} : '0;
  assign iv_eff = (iv_r < btrm_pkg::IV_MIN) ? btrm_pkg::IV_MIN : iv_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign rd_tick  = rd_vld_r ? rd_tick_r : '0;
  assign rd_bytes = rd_vld_r ? rd_bytes_r : '0;
  assign in_win   = all_r || (rd_tick >= bnd_r);
  assign elapsed  = tick_r - start_r;

  btrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    byte_nxt      = byte_r;
    tick_nxt      = tick_r;
    bnd_nxt       = bnd_r;
    all_nxt       = all_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    old_nxt       = old_r;
    ring_nxt      = ring_r;
    sum_nxt       = sum_r;
    start_nxt     = start_r;
    res_nxt       = res_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rate_nxt  = out_rate_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = found_r ? slot_r : ring_r;
    wr_bytes      = (found_r ? old_r : '0) +
                    {{(btrm_pkg::SUM_W - btrm_pkg::BYTES_W){1'b0}}, byte_r};
    div_req       = '0;
    div_dividend  = {in_current_time, {(btrm_pkg::DIV_W - btrm_pkg::TIME_W){1'b0}}};
    div_divisor   = {{(btrm_pkg::DEN_W - btrm_pkg::IV_W){1'b0}}, iv_eff};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          byte_nxt      = in_byte_count;
          div_req.start = 1'b1;
          div_req.wide  = 1'b0;
          state_nxt     = ST_TICK;
        end
      end
      ST_TICK: begin
        if (div_done) begin
          tick_nxt  = div_quot[btrm_pkg::TIME_W-1:0];
          bnd_nxt   = div_quot[btrm_pkg::TIME_W-1:0] - btrm_pkg::TIME_W'(BUCKETS);
          all_nxt   = div_quot[btrm_pkg::TIME_W-1:0] < btrm_pkg::TIME_W'(BUCKETS);
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          old_nxt   = '0;
          sum_nxt   = '0;
          start_nxt = btrm_pkg::TICK_MAX;
          state_nxt = (byte_r != '0) ? ST_SRCH : ST_SCAN;
        end
      end
      ST_SRCH: begin
        if (pend_r && !found_r && (rd_tick == tick_r)) begin
          found_nxt = 1'b1;
          slot_nxt  = pidx_r;
          old_nxt   = rd_bytes;
        end
        if (idx_r != CW'(BUCKETS)) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        wr_en            = 1'b1;
        vld_nxt[wr_addr] = 1'b1;
        if (!found_r) begin
          ring_nxt = (ring_r == AW'(BUCKETS - 1)) ? '0 : ring_r + AW'(1);
        end
        idx_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (pend_r && in_win) begin
          sum_nxt = sum_r + rd_bytes;
          if (rd_tick < start_r) begin
            start_nxt = rd_tick;
          end
        end
        if (idx_r != CW'(BUCKETS)) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        div_dividend = sum_r;
        div_divisor  = btrm_pkg::DEN_W'(elapsed) * btrm_pkg::DEN_W'(iv_eff);
        if (tick_r > start_r) begin
          div_req.start = 1'b1;
          div_req.wide  = 1'b1;
          state_nxt     = ST_QUOT;
        end else begin
          res_nxt   = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_QUOT: begin
        if (div_done) begin
          res_nxt = (div_quot[btrm_pkg::DIV_W-1:btrm_pkg::RATE_W] != '0) ?
                    btrm_pkg::RATE_SAT : div_quot[btrm_pkg::RATE_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rate_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iv_r        <= btrm_pkg::IV_RST;
      ring_r      <= '0;
      vld_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ring_r      <= ring_nxt;
      vld_r       <= vld_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        iv_r <= pwdata[btrm_pkg::IV_W-1:0];
      end
    end
    byte_r     <= byte_nxt;
    tick_r     <= tick_nxt;
    bnd_r      <= bnd_nxt;
    all_r      <= all_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    slot_r     <= slot_nxt;
    old_r      <= old_nxt;
    sum_r      <= sum_nxt;
    start_r    <= start_nxt;
    res_r      <= res_nxt;
    out_rate_r <= out_rate_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tick_mem[wr_addr]  <= tick_r;
      bytes_mem[wr_addr] <= wr_bytes;
    end
    if (rd_en) begin
      rd_tick_r  <= tick_mem[rd_addr];
      rd_bytes_r <= bytes_mem[rd_addr];
      rd_vld_r   <= vld_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_rate  = out_rate_r;

endmodule

### hw/rtl/btrm_checker.sv
// Port-level checker for the transfer rate meter and its bind.
`include "assert_macros.svh"

module btrm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [btrm_pkg::RATE_W-1:0]    out_rate,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [btrm_pkg::ADDR_W-1:0]    paddr,
  input logic [btrm_pkg::DATA_W-1:0]    pwdata,
  input logic [btrm_pkg::DATA_W-1:0]    prdata,
  input logic                           pready
);

  logic                       in_xfer;
  logic                       out_stall;
  logic                       iv_sel;
  logic                       iv_wr;
  logic [btrm_pkg::IV_W-1:0]  iv_rd;
  logic [btrm_pkg::IV_W-1:0]  iv_wd;

  assign in_xfer   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign iv_sel    = (paddr[btrm_pkg::ADDR_W-1:2] == btrm_pkg::REG_INTERVAL);
  assign iv_wr     = psel && penable && pwrite && pready && iv_sel;
  assign iv_rd     = prdata[btrm_pkg::IV_W-1:0];
  assign iv_wd     = pwdata[btrm_pkg::IV_W-1:0];

  `ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_rate), "result changed while stalled")
  `ASSERT_NXT(a_busy_after_accept, in_xfer, !in_ready, "ready again right after a transfer")
  `ASSERT_IMP(a_result_at_idle, $rose(out_valid), in_ready, "result shown while still busy")
  `ASSERT_NXT(a_cfg_readback, iv_wr, !iv_sel || (iv_rd == $past(iv_wd)), "interval readback mismatch")

endmodule

bind bucketed_transfer_rate_meter_unit btrm_checker u_btrm_checker (.*);

### test/bucketed_transfer_rate_meter_unit_tb.sv
// Self-checking testbench for the bucketed transfer rate meter: directed rows, then random sessions.
module bucketed_transfer_rate_meter_unit_tb;
  import btrm_pkg::*;

  localparam int NBUCKET      = BUCKETS_DEF;
  localparam int MAX_SHOWN    = 10;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int LONG_HOLD    = 1000;
  localparam int NPHASE       = 9;
  localparam int PHASE_ITEMS  = 100;
  localparam logic [ADDR_W-1:0] INTERVAL_ADDR = ADDR_W'(REG_INTERVAL) << 2;
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = (ADDR_W'(REG_INTERVAL) + 1'b1) << 2;

  typedef enum {ROW_XFER, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
    logic [TIME_W-1:0]   now;
    logic [BYTES_W-1:0]  bytes;
    bit                  known;
    logic [RATE_W-1:0]   rate;
  } dir_row_t;

  typedef struct {
    logic [TIME_W-1:0]  now;
    logic [BYTES_W-1:0] bytes;
    logic [RATE_W-1:0]  rate;
  } rate_expect_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [TIME_W-1:0]   in_current_time;
  logic [BYTES_W-1:0]  in_byte_count;
  logic                out_valid;
  logic                out_ready;
  logic [RATE_W-1:0]   out_rate;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [IV_W-1:0]     interval_reg;
  logic [TIME_W-1:0]   tick_of_bucket[NBUCKET];
  logic [SUM_W-1:0]    bytes_of_bucket[NBUCKET];
  int                  next_bucket;

  rate_expect_t        rate_expect_q[$];
  rate_expect_t        got_head;
  dir_row_t            dir_rows[$];
  int                  fail_cnt = 0;
  int                  cycle_cnt = 0;
  int                  tx_gap_pct = 0;
  int                  rx_stall_pct = 0;
  bit                  hold_request = 1'b0;
  int unsigned         phase_iv[NPHASE]     = '{2, 0, 4095, 1, 3600, 3, 2, 17, 2};
  int                  phase_tx_pct[NPHASE] = '{10, 5, 20, 0, 15, 30, 10, 5, 0};
  int                  phase_rx_pct[NPHASE] = '{5, 3, 10, 8, 0, 12, 6, 4, 0};

  bucketed_transfer_rate_meter_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_current_time (in_current_time),
    .in_byte_count   (in_byte_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rate        (out_rate),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void note_failure(string msg);
    if (fail_cnt < MAX_SHOWN) $display("ERROR: %s", msg);
    fail_cnt++;
  endfunction

  function automatic logic [RATE_W-1:0] predict_rate(logic [TIME_W-1:0] now,
                                                      logic [BYTES_W-1:0] bytes);
    logic [IV_W-1:0]   iv;
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] first_tick;
    logic [SUM_W-1:0]  total;
    logic [SUM_W-1:0]  span;
    longint            floor_tick;
    int                slot;
    int                i;
    iv = (interval_reg < IV_MIN) ? IV_MIN : interval_reg;
    tick = now / TIME_W'(iv);
    if (bytes != '0) begin
      slot = -1;
      for (i = 0; i < NBUCKET; i++)
        if (slot < 0 && tick_of_bucket[i] == tick) slot = i;
      if (slot < 0) begin
        slot = next_bucket;
        tick_of_bucket[slot] = tick;
        bytes_of_bucket[slot] = '0;
        next_bucket = (next_bucket + 1) % NBUCKET;
      end
      bytes_of_bucket[slot] += SUM_W'(bytes);
    end
    floor_tick = longint'(tick) - longint'(NBUCKET);
    total = '0;
    first_tick = TICK_MAX;
    for (i = 0; i < NBUCKET; i++) begin
      if (longint'(tick_of_bucket[i]) >= floor_tick) begin
        total += bytes_of_bucket[i];
        if (tick_of_bucket[i] < first_tick) first_tick = tick_of_bucket[i];
      end
    end
    if (tick <= first_tick) return '0;
    span = SUM_W'(tick - first_tick) * SUM_W'(iv);
    total = total / span;
    return (total > SUM_W'(RATE_SAT)) ? RATE_SAT : total[RATE_W-1:0];
  endfunction

  function automatic void add_xfer(logic [TIME_W-1:0] now, logic [BYTES_W-1:0] bytes,
                                   bit known, logic [RATE_W-1:0] rate);
    dir_row_t r;
    r.kind = ROW_XFER;
    r.addr = '0;
    r.wdata = '0;
    r.now = now;
    r.bytes = bytes;
    r.known = known;
    r.rate = rate;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    dir_row_t r;
    r.kind = ROW_CFG;
    r.addr = addr;
    r.wdata = data;
    r.now = '0;
    r.bytes = '0;
    r.known = 1'b0;
    r.rate = '0;
    dir_rows.push_back(r);
  endfunction

  task automatic send_transfer(input logic [TIME_W-1:0] now, input logic [BYTES_W-1:0] bytes,
                               input bit known, input logic [RATE_W-1:0] typed_rate);
    int           gap;
    rate_expect_t e;
    gap = (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_current_time <= now;
    in_byte_count <= bytes;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e.now = now;
    e.bytes = bytes;
    e.rate = predict_rate(now, bytes);
    if (known) e.rate = typed_rate;
    rate_expect_q.push_back(e);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rate_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[ADDR_W-1:2] == REG_INTERVAL) interval_reg = data[IV_W-1:0];
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (rate_expect_q.size() == 0) begin
        note_failure($sformatf("rate %h with no transfer pending", out_rate));
      end else begin
        got_head = rate_expect_q.pop_front();
        if (out_rate !== got_head.rate)
          note_failure($sformatf("time %h bytes %h: rate expected %h, got %h",
                                 got_head.now, got_head.bytes, got_head.rate, out_rate));
      end
    end
  end

  initial begin
    int low_left;
    low_left = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        low_left = LONG_HOLD;
      end else if (low_left == 0 && rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        low_left = $urandom_range(1, 18);
      end
      if (low_left > 0) begin
        low_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    logic [TIME_W-1:0]  clock_s;
    logic [TIME_W-1:0]  t;
    logic [BYTES_W-1:0] b;
    logic [DATA_W-1:0]  cfg_word;
    int unsigned        iv_eff;
    int                 roll;
    int                 ph;
    int                 n;
    int                 i;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_current_time <= '0;
    in_byte_count <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    interval_reg = IV_RST;
    for (i = 0; i < NBUCKET; i++) begin
      tick_of_bucket[i] = '0;
      bytes_of_bucket[i] = '0;
    end
    next_bucket = 0;
    phase_iv[6] = $urandom_range(2, 4095);

    add_xfer(32'd0, 32'd0, 1'b1, '0);
    add_xfer(32'd2, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF);
    add_xfer(32'd3, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    add_xfer(32'd3, 32'hFFFF_FFFF, 1'b1, RATE_SAT);
    add_xfer(32'd0, 32'd1, 1'b0, '0);
    add_xfer(32'h8000_0000, 32'd0, 1'b1, '0);
    add_xfer(32'hFFFF_FFFF, 32'd0, 1'b1, '0);
    add_xfer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);
    add_xfer(32'd0, 32'hFFFF_FFFF, 1'b0, '0);
    add_xfer(32'd64, 32'd100, 1'b0, '0);
    add_xfer(32'd66, 32'd0, 1'b0, '0);
    add_cfg(INTERVAL_ADDR, 32'd0);
    add_xfer(32'd71, 32'd7, 1'b0, '0);
    add_cfg(INTERVAL_ADDR, 32'd1);
    add_xfer(32'd75, 32'd0, 1'b0, '0);
    add_cfg(INTERVAL_ADDR, 32'd4095);
    add_xfer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_xfer(32'd0, 32'd0, 1'b0, '0);
    add_cfg(UNMAPPED_ADDR, 32'd7);
    add_xfer(32'd8190, 32'd3, 1'b0, '0);
    add_cfg(INTERVAL_ADDR, 32'hFFFF_F00A);
    add_xfer(32'd200, 32'd55, 1'b0, '0);
    add_xfer(32'd230, 32'd1, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_gap_pct = 15;
    rx_stall_pct = 5;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG)
        write_reg(dir_rows[k].addr, dir_rows[k].wdata);
      else
        send_transfer(dir_rows[k].now, dir_rows[k].bytes, dir_rows[k].known, dir_rows[k].rate);
    end

    for (ph = 0; ph < NPHASE; ph++) begin
      tx_gap_pct = phase_tx_pct[ph];
      rx_stall_pct = phase_rx_pct[ph];
      cfg_word = $urandom();
      cfg_word[IV_W-1:0] = IV_W'(phase_iv[ph]);
      write_reg(INTERVAL_ADDR, cfg_word);
      iv_eff = (phase_iv[ph] < IV_MIN) ? IV_MIN : phase_iv[ph];
      case ($urandom_range(0, 3))
        0, 1:    clock_s = $urandom_range(0, 100 * iv_eff);
        2:       clock_s = $urandom();
        default: clock_s = TICK_MAX - $urandom_range(0, 60 * iv_eff);
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 40) hold_request = 1'b1;
        if (ph == 2 && n == 50) wait_drained();
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          t = $urandom();
          b = $urandom();
        end else begin
          if (roll < 16)
            clock_s += NBUCKET * iv_eff;
          else if (roll < 20)
            clock_s += $urandom_range(NBUCKET - 2, NBUCKET + 2) * iv_eff
                       + $urandom_range(0, iv_eff - 1);
          else
            clock_s += $urandom_range(0, 2 * iv_eff);
          t = clock_s;
          roll = $urandom_range(0, 99);
          if (roll < 15)      b = '0;
          else if (roll < 55) b = $urandom_range(1, 5000);
          else if (roll < 85) b = $urandom();
          else                b = 32'hFFFF_FFFF - $urandom_range(0, 3);
        end
        send_transfer(t, b, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
